### rtl/core/bwf_pkg.sv
// Shared types, constants and the exponent table of the bilateral window filter.
// Used by bwf_div and bilateral_window_filter; depends on nothing.
package bwf_pkg;

    localparam int IMG_DIM       = 256;
    localparam int COORD_W       = 8;
    localparam int NUM_CH        = 3;
    localparam int MAX_RAD       = 9;
    localparam int EXP_DEPTH     = 256;
    localparam int PIX_W         = 16;
    localparam int WT_W          = 17;
    localparam int ACC_W         = 42;
    localparam int WSUM_W        = 26;
    localparam int QUOT_W        = 17;
    localparam logic [31:0] EXP_STEP_Q32 = 32'd4034748383;

    typedef enum logic [2:0] {
        CFG_WIDTH  = 3'd0,
        CFG_HEIGHT = 3'd1,
        CFG_CHANS  = 3'd2,
        CFG_RADIUS = 3'd3,
        CFG_SPACE  = 3'd4,
        CFG_RANGE  = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CENTRE,
        ST_WALK,
        ST_DRAIN,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef logic [WT_W-1:0] exp_rom_t [EXP_DEPTH];

    function automatic exp_rom_t build_rom();
        exp_rom_t    rom;
        logic [95:0] r;
        logic [95:0] p;
        r = 96'd1 << 32;
        for (int k = 0; k < EXP_DEPTH; k++) begin
            p = r + 96'h8000;
            rom[k] = p[16+WT_W-1:16];
            p = r * {64'd0, EXP_STEP_Q32} + 96'h8000_0000;
            r = p >> 32;
        end
        return rom;
    endfunction

    localparam exp_rom_t EXP_ROM = build_rom();

    typedef struct packed {
        logic                     start;
        logic signed [ACC_W-1:0]  num;
        logic [WSUM_W-1:0]        den;
    } div_req_t;

endpackage

### rtl/core/bwf_div.sv
// Bit-serial rounding divider with 16-bit saturation, one quotient bit per cycle.
// Depends on bwf_pkg.
module bwf_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  bwf_pkg::div_req_t              req,
    output logic                           done,
    output logic signed [bwf_pkg::PIX_W-1:0] quot
);
    localparam int NW = bwf_pkg::ACC_W + 1;
    localparam int QW = bwf_pkg::QUOT_W;
    localparam int RW = bwf_pkg::WSUM_W + 1;

    logic                  busy_reg;
    logic [4:0]            cnt_reg;
    logic [RW-1:0]         rem_reg;
    logic [QW-1:0]         low_reg;
    logic [QW-1:0]         q_reg;
    logic [bwf_pkg::WSUM_W-1:0] den_reg;
    logic                  neg_reg;
    logic                  done_reg;
    logic signed [bwf_pkg::PIX_W-1:0] quot_reg;

    logic [bwf_pkg::ACC_W-1:0] mag;
    logic [NW-1:0]         n_full;
    logic [RW-1:0]         t;
    logic                  ge;
    logic [QW-1:0]         q_next;

    always_comb begin
        mag    = req.num[bwf_pkg::ACC_W-1] ? bwf_pkg::ACC_W'(-req.num) : req.num;
        n_full = {1'b0, mag} + NW'(req.den >> 1);
        t      = {rem_reg[RW-2:0], low_reg[QW-1]};
        ge     = t >= {1'b0, den_reg};
        q_next = {q_reg[QW-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == 5'd0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            cnt_reg <= 5'(QW - 1);
            rem_reg <= {1'b0, n_full[NW-1:QW]};
            low_reg <= n_full[QW-1:0];
            q_reg   <= '0;
            den_reg <= req.den;
            neg_reg <= req.num[bwf_pkg::ACC_W-1];
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 5'd1;
            rem_reg <= ge ? t - {1'b0, den_reg} : t;
            low_reg <= {low_reg[QW-2:0], 1'b0};
            q_reg   <= q_next;
            if (cnt_reg == 5'd0) begin
                if (neg_reg) begin
                    quot_reg <= (q_next > QW'(32768)) ? 16'sh8000
                                                      : bwf_pkg::PIX_W'(-q_next);
                end else begin
                    quot_reg <= (q_next > QW'(32767)) ? 16'sh7fff
                                                      : bwf_pkg::PIX_W'(q_next);
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

    assert property (@(posedge aclk) disable iff (!aresetn) req.start |-> !busy_reg)
        else $error("divider restarted while busy");
    assert property (@(posedge aclk) disable iff (!aresetn) done_reg |-> !busy_reg)
        else $error("divider done while busy");
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> rem_reg < {1'b0, den_reg})
        else $error("divider remainder out of range");

endmodule

### rtl/core/bilateral_window_filter.sv
// Bilateral window filter top level: frame store, tap walk, weight pipeline, divider.
// Depends on bwf_pkg and bwf_div.
//
// channel  dir  tdata (low bit up)                        tuser
// s_       in   row, col, chan0_in, chan1_in, chan2_in    kind
// m_       out  out_row, out_col, chan0_out..chan2_out    -
// cfg_     in   write enable, register index, data        -
//
// A query walks (2r+1)^2 taps at one per cycle, then drains the weight pipeline
// and runs the divider once for each of the three channels. The single frame store
// read port sets the tap rate. Synchronous reset clears control state only; the
// frame store holds garbage until written. New items are taken while a finished
// result waits on m_tready.
module bilateral_window_filter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // row[7:0], col[15:8], chan0..2 [63:16]
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // out_row[7:0], out_col[15:8], chan0..2 [63:16]
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [19:0] cfg_wdata
);
    localparam int PW = bwf_pkg::PIX_W;
    localparam int NC = bwf_pkg::NUM_CH;

    logic [8:0]  width_reg, height_reg;
    logic [1:0]  chans_reg;
    logic [3:0]  radius_reg;
    logic [15:0] space_reg;
    logic [19:0] range_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
            chans_reg  <= 2'd3;
            radius_reg <= 4'd9;
            space_reg  <= 16'd228;
            range_reg  <= 20'd51200;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                bwf_pkg::CFG_WIDTH:  width_reg  <= cfg_wdata[8:0];
                bwf_pkg::CFG_HEIGHT: height_reg <= cfg_wdata[8:0];
                bwf_pkg::CFG_CHANS:  chans_reg  <= cfg_wdata[1:0];
                bwf_pkg::CFG_RADIUS: radius_reg <= cfg_wdata[3:0];
                bwf_pkg::CFG_SPACE:  space_reg  <= cfg_wdata[15:0];
                bwf_pkg::CFG_RANGE:  range_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic [8:0] w_eff, h_eff;
    logic [1:0] nch_eff;
    logic [3:0] rad_eff;
    logic signed [4:0] rad_s;

    always_comb begin
        w_eff   = (width_reg == 9'd0) ? 9'd1 : (width_reg > 9'd256 ? 9'd256 : width_reg);
        h_eff   = (height_reg == 9'd0) ? 9'd1 : (height_reg > 9'd256 ? 9'd256 : height_reg);
        nch_eff = (chans_reg == 2'd0) ? 2'd1 : chans_reg;
        rad_eff = (radius_reg > 4'(bwf_pkg::MAX_RAD)) ? 4'(bwf_pkg::MAX_RAD) : radius_reg;
        rad_s   = signed'({1'b0, rad_eff});
    end

    bwf_pkg::state_t state_reg, state_next;
    logic [7:0]  row_reg, col_reg;
    logic signed [4:0] dy_reg, dx_reg;
    logic [1:0]  ch_reg;
    logic signed [PW-1:0] centre_reg [NC];
    logic signed [PW-1:0] res_reg [NC];
    logic        m_tvalid_reg;
    logic [63:0] m_tdata_reg;

    logic        s_acc, is_query, in_img, load_out;
    logic        pipe_busy, walk_last;
    logic [15:0] rd_addr;
    logic [47:0] rd_reg;
    logic        v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    logic [7:0]  dd2_issue, p0_dd2_reg, s1_dd2_reg;
    logic [7:0]  sy, sx;
    logic        div_start, div_done;
    logic [1:0]  div_ch;
    logic signed [PW-1:0] div_quot;
    bwf_pkg::div_req_t div_req;

    logic signed [bwf_pkg::ACC_W-1:0] acc_reg [NC];
    logic [bwf_pkg::WSUM_W-1:0] wsum_reg;

    logic [47:0] mem [bwf_pkg::IMG_DIM * bwf_pkg::IMG_DIM];

    assign s_tready = (state_reg == bwf_pkg::ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign is_query = s_tuser;
    assign in_img   = ({1'b0, s_tdata[7:0]} < h_eff) && ({1'b0, s_tdata[15:8]} < w_eff);
    assign pipe_busy = v0_reg | v1_reg | v2_reg | v3_reg | v4_reg;
    assign walk_last = (dx_reg == rad_s) && (dy_reg == rad_s);

    logic signed [9:0] ty, tx;
    logic signed [9:0] dxsq, dysq;
    always_comb begin
        ty = signed'({2'b00, row_reg}) + 10'(dy_reg);
        tx = signed'({2'b00, col_reg}) + 10'(dx_reg);
        if (ty < 0) sy = 8'd0;
        else if (ty >= signed'({1'b0, h_eff})) sy = 8'(h_eff - 9'd1);
        else sy = ty[7:0];
        if (tx < 0) sx = 8'd0;
        else if (tx >= signed'({1'b0, w_eff})) sx = 8'(w_eff - 9'd1);
        else sx = tx[7:0];
        dxsq = dx_reg * dx_reg;
        dysq = dy_reg * dy_reg;
        dd2_issue = dxsq[7:0] + dysq[7:0];
        rd_addr = (state_reg == bwf_pkg::ST_IDLE) ? {s_tdata[7:0], s_tdata[15:8]} : {sy, sx};
    end

    always_ff @(posedge aclk) begin
        if (s_acc && !is_query) begin
            mem[{s_tdata[7:0], s_tdata[15:8]}] <= s_tdata[63:16];
        end
        rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bwf_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        div_start  = 1'b0;
        div_ch     = 2'd0;
        load_out   = 1'b0;
        unique case (state_reg)
            bwf_pkg::ST_IDLE: begin
                if (s_acc && is_query && in_img) state_next = bwf_pkg::ST_CENTRE;
            end
            bwf_pkg::ST_CENTRE: state_next = bwf_pkg::ST_WALK;
            bwf_pkg::ST_WALK: begin
                if (walk_last) state_next = bwf_pkg::ST_DRAIN;
            end
            bwf_pkg::ST_DRAIN: begin
                if (!pipe_busy) begin
                    div_start  = 1'b1;
                    state_next = bwf_pkg::ST_DIV;
                end
            end
            bwf_pkg::ST_DIV: begin
                div_ch = ch_reg + 2'd1;
                if (div_done) begin
                    if (ch_reg == 2'(NC - 1)) state_next = bwf_pkg::ST_DONE;
                    else div_start = 1'b1;
                end
            end
            bwf_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    load_out   = 1'b1;
                    state_next = bwf_pkg::ST_IDLE;
                end
            end
            default: state_next = bwf_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            row_reg <= s_tdata[7:0];
            col_reg <= s_tdata[15:8];
        end
        if (state_reg == bwf_pkg::ST_CENTRE) begin
            for (int c = 0; c < NC; c++) centre_reg[c] <= rd_reg[c*PW +: PW];
            dy_reg <= -rad_s;
            dx_reg <= -rad_s;
        end else if (state_reg == bwf_pkg::ST_WALK) begin
            if (dx_reg == rad_s) begin
                dx_reg <= -rad_s;
                dy_reg <= dy_reg + 5'sd1;
            end else begin
                dx_reg <= dx_reg + 5'sd1;
            end
        end
        if (state_reg == bwf_pkg::ST_DRAIN) ch_reg <= 2'd0;
        else if (state_reg == bwf_pkg::ST_DIV && div_done) begin
            res_reg[ch_reg] <= div_quot;
            ch_reg <= ch_reg + 2'd1;
        end
    end

    // weight pipeline
    logic signed [PW:0]   d [NC];
    logic signed [2*PW+1:0] dsq [NC];
    logic [31:0]  s1_sq_reg [NC];
    logic [47:0]  s1_tap_reg, s2_tap_reg, s3_tap_reg;
    logic [33:0]  feat;
    logic [53:0]  s2_rng_reg;
    logic [23:0]  s2_spc_reg;
    logic [55:0]  arg;
    logic [bwf_pkg::WT_W-1:0] wt, s3_wt_reg, s4_wt_reg;
    logic signed [2*PW+1:0] s4_prod_reg [NC];

    always_comb begin
        for (int c = 0; c < NC; c++) begin
            d[c]   = signed'({centre_reg[c][PW-1], centre_reg[c]})
                   - signed'({rd_reg[c*PW+PW-1], rd_reg[c*PW +: PW]});
            dsq[c] = d[c] * d[c];
        end
        feat = 34'(s1_sq_reg[0]) + 34'(s1_sq_reg[1]) + 34'(s1_sq_reg[2]);
        arg  = 56'(s2_rng_reg) + (56'(s2_spc_reg) << 26);
        wt   = (arg[55:34] < 22'(bwf_pkg::EXP_DEPTH)) ? bwf_pkg::EXP_ROM[arg[41:34]] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v0_reg <= (state_reg == bwf_pkg::ST_WALK);
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        p0_dd2_reg <= dd2_issue;
        s1_dd2_reg <= p0_dd2_reg;
        s1_tap_reg <= rd_reg;
        for (int c = 0; c < NC; c++) begin
            s1_sq_reg[c] <= (2'(c) < nch_eff) ? dsq[c][31:0] : 32'd0;
        end
        s2_rng_reg <= feat * range_reg;
        s2_spc_reg <= s1_dd2_reg * space_reg;
        s2_tap_reg <= s1_tap_reg;
        s3_wt_reg  <= wt;
        s3_tap_reg <= s2_tap_reg;
        s4_wt_reg  <= s3_wt_reg;
        for (int c = 0; c < NC; c++) begin
            s4_prod_reg[c] <= signed'({1'b0, s3_wt_reg}) * signed'(s3_tap_reg[c*PW +: PW]);
        end
        if (state_reg == bwf_pkg::ST_CENTRE) begin
            wsum_reg <= '0;
            for (int c = 0; c < NC; c++) acc_reg[c] <= '0;
        end else if (v4_reg) begin
            wsum_reg <= wsum_reg + bwf_pkg::WSUM_W'(s4_wt_reg);
            for (int c = 0; c < NC; c++) begin
                acc_reg[c] <= acc_reg[c] + bwf_pkg::ACC_W'(s4_prod_reg[c]);
            end
        end
    end

    always_comb begin
        div_req.start = div_start;
        div_req.den   = wsum_reg;
        case (div_ch)
            2'd1:    div_req.num = acc_reg[1];
            2'd2:    div_req.num = acc_reg[2];
            default: div_req.num = acc_reg[0];
        endcase
    end

    bwf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_tdata_reg[7:0]  <= row_reg;
            m_tdata_reg[15:8] <= col_reg;
            for (int c = 0; c < NC; c++) begin
                m_tdata_reg[16 + c*PW +: PW] <= (2'(c) < nch_eff) ? res_reg[c] : '0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == bwf_pkg::ST_IDLE |-> !pipe_busy)
        else $error("tap pipeline busy while idle");
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == bwf_pkg::ST_DIV)
        else $error("divider result outside divide phase");
    assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> (!m_tvalid_reg || m_tready))
        else $error("output register overwritten");
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == bwf_pkg::ST_WALK |-> (dx_reg <= rad_s) && (dy_reg <= rad_s))
        else $error("tap walk beyond window");

endmodule
